@@ sv/assert_macros.svh @@
// Assertion helpers shared by the tilt filter RTL.
// Every macro samples on posedge clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/cft_pkg.sv @@
`timescale 1ns / 1ps

package cft_pkg;

    localparam int IN_W       = 16;
    localparam int ANG_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int MAG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Q1.16 unity weight
    localparam int ONE_Q16 = 65536;

    // CORDIC datapath
    localparam int TAB_LEN   = 24;
    localparam int TAB_IDX_W = 5;
    localparam int TAB_W     = 30;
    localparam int TAB_FRAC  = 24;
    localparam int CV_W      = 34;
    localparam int Z_W       = 34;
    localparam int PRE_SH    = 14;
    localparam int DEG90_Z   = 90 * (1 << TAB_FRAC);

    // saturation input width
    localparam int SAT_W = 36;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_CORDIC,
        ST_MERGE,
        ST_OUT
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_GAIN,
        CFG_KEEP_WEIGHT,
        CFG_MAG_LOW,
        CFG_MAG_HIGH
    } cfg_idx_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
        logic [TAB_W-1:0] v;
        case (i)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        logic signed [ANG_W-1:0] r;
        hi = SAT_W'(2147483647);
        lo = -hi - SAT_W'(1);
        if (v > hi)
        begin
            r = ANG_W'(hi);
        end
        else if (v < lo)
        begin
            r = ANG_W'(lo);
        end
        else
        begin
            r = ANG_W'(v);
        end
        return r;
    endfunction

endpackage

@@ sv/cft_cordic.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Iterative vectoring CORDIC lane: atan2(y, x) in degrees, one step per cycle.
module cft_cordic #(
    parameter int STEPS     = 16,
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [cft_pkg::IN_W-1:0]    y_in,
    input  logic signed [cft_pkg::IN_W-1:0]    x_in,
    output logic                               done,
    output logic signed [ACC_W-1:0]            angle
);
    import cft_pkg::*;

    localparam int ITERS     = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
    localparam int CNT_W     = $clog2(ITERS);
    localparam int RND_SH    = TAB_FRAC - FRAC_BITS;
    localparam int RND_HALF  = 1 << (RND_SH - 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ITERS - 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic                     zero_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [CV_W-1:0]   cx_reg, cx_next;
    logic signed [CV_W-1:0]   cy_reg, cy_next;
    logic signed [Z_W-1:0]    z_reg, z_next;

    logic signed [CV_W-1:0]   xe, ye, cx0, cy0, sx, sy;
    logic signed [Z_W-1:0]    z0, ta, zr;

    // quadrant fold on load, micro-rotation while busy
    always_comb
    begin
        xe = CV_W'(x_in);
        ye = CV_W'(y_in);
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                cx0 = ye;
                cy0 = -xe;
                z0  = Z_W'(DEG90_Z);
            end
            else
            begin
                cx0 = -ye;
                cy0 = xe;
                z0  = -Z_W'(DEG90_Z);
            end
        end
        else
        begin
            cx0 = xe;
            cy0 = ye;
            z0  = '0;
        end

        sx = cx_reg >>> cnt_reg;
        sy = cy_reg >>> cnt_reg;
        ta = $signed(Z_W'(atan_entry(TAB_IDX_W'(cnt_reg))));

        if (start)
        begin
            cx_next = cx0 <<< PRE_SH;
            cy_next = cy0 <<< PRE_SH;
            z_next  = z0;
        end
        else if (busy_reg)
        begin
            if (cy_reg > 0)
            begin
                cx_next = cx_reg + sy;
                cy_next = cy_reg - sx;
                z_next  = z_reg + ta;
            end
            else
            begin
                cx_next = cx_reg - sy;
                cy_next = cy_reg + sx;
                z_next  = z_reg - ta;
            end
        end
        else
        begin
            cx_next = cx_reg;
            cy_next = cy_reg;
            z_next  = z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        z_reg  <= z_next;
        if (start)
        begin
            zero_reg <= (x_in == 0) && (y_in == 0);
        end
    end

    // round half up to the output fraction
    assign zr    = (z_reg + Z_W'(RND_HALF)) >>> RND_SH;
    assign angle = zero_reg ? '0 : ACC_W'(zr);
    assign done  = done_reg;

    `ASSERT_IMP(a_no_restart, start, !busy_reg)
    `ASSERT_NXT(a_last_step, busy_reg && (cnt_reg == LAST), done_reg && !busy_reg)
    `ASSERT_NXT(a_done_pulse, done_reg, !done_reg)

endmodule

@@ sv/cft_merge.sv @@
`timescale 1ns / 1ps

// Blends both integrated angles toward their lane results; two stages.
module cft_merge #(
    parameter int ACC_W = 26
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [cft_pkg::ANG_W-1:0]    pitch_in,
    input  logic signed [cft_pkg::ANG_W-1:0]    roll_in,
    input  logic signed [ACC_W-1:0]             acc_pitch,
    input  logic signed [ACC_W-1:0]             acc_roll,
    input  logic [cft_pkg::WEIGHT_W-1:0]        keep,
    output logic                                done,
    output logic signed [cft_pkg::ANG_W-1:0]    pitch_new,
    output logic signed [cft_pkg::ANG_W-1:0]    roll_new
);
    import cft_pkg::*;

    localparam int KP_W  = ANG_W + WEIGHT_W;
    localparam int AP_W  = ACC_W + WEIGHT_W;
    localparam int SUM_W = 51;

    logic [WEIGHT_W-1:0]       kc, kr;
    logic signed [KP_W-1:0]    kp_p_reg, kp_r_reg;
    logic signed [AP_W-1:0]    ap_p_reg, ap_r_reg;
    logic signed [SUM_W-1:0]   sum_p, sum_r;
    logic signed [SUM_W-1:0]   sh_p, sh_r;
    logic                      stage_reg;
    logic                      done_reg;
    logic signed [ANG_W-1:0]   pitch_new_reg, roll_new_reg;

    always_comb
    begin
        kc = (keep > WEIGHT_W'(ONE_Q16)) ? WEIGHT_W'(ONE_Q16) : keep;
        kr = WEIGHT_W'(ONE_Q16) - kc;
        sum_p = SUM_W'(kp_p_reg) + SUM_W'(ap_p_reg) + SUM_W'(32768);
        sum_r = SUM_W'(kp_r_reg) + SUM_W'(ap_r_reg) + SUM_W'(32768);
        sh_p  = sum_p >>> 16;
        sh_r  = sum_r >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kp_p_reg <= KP_W'(pitch_in) * KP_W'($signed({1'b0, kc}));
            kp_r_reg <= KP_W'(roll_in) * KP_W'($signed({1'b0, kc}));
            ap_p_reg <= AP_W'(acc_pitch) * AP_W'($signed({1'b0, kr}));
            ap_r_reg <= AP_W'(acc_roll) * AP_W'($signed({1'b0, kr}));
        end
        if (stage_reg)
        begin
            pitch_new_reg <= sat32(SAT_W'(sh_p));
            roll_new_reg  <= sat32(SAT_W'(sh_r));
        end
    end

    assign done      = done_reg;
    assign pitch_new = pitch_new_reg;
    assign roll_new  = roll_new_reg;

endmodule

@@ sv/imu_complementary_tilt_filter_top.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Path: without accel blend a transaction passes ST_INTEG and ST_OUT to the output
//   register; blended ones also pass ST_CORDIC, one lane step per cycle, and ST_MERGE.
// Flow: one transaction at a time; the next can be taken the cycle after the result
//   is loaded into the output register.
// Reset (async, active low): angles clear to 0; config and out_valid take defaults.
module imu_complementary_tilt_filter_top #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [cft_pkg::IN_W-1:0]       accel_x,
    input  logic signed [cft_pkg::IN_W-1:0]       accel_y,
    input  logic signed [cft_pkg::IN_W-1:0]       accel_z,
    input  logic signed [cft_pkg::IN_W-1:0]       gyro_x,
    input  logic signed [cft_pkg::IN_W-1:0]       gyro_y,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [cft_pkg::ANG_W-1:0]      pitch_out,
    output logic signed [cft_pkg::ANG_W-1:0]      roll_out,
    output logic                                  accel_applied,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [cft_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cft_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import cft_pkg::*;

    // lane result: +/-190 degrees with ANGLE_FRAC_BITS fraction, plus headroom
    localparam int ACC_W  = ANGLE_FRAC_BITS + 10;
    localparam int GP_W   = IN_W + GAIN_W + 1;
    localparam int ABS_W  = IN_W + 1;
    localparam int SUMM_W = MAG_W + 1;

    function automatic logic [ABS_W-1:0] abs16(input logic signed [IN_W-1:0] v);
        logic signed [ABS_W-1:0] e;
        e = ABS_W'(v);
        return v[IN_W-1] ? ABS_W'(-e) : ABS_W'(e);
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [GAIN_W-1:0]    gyro_gain_reg;
    logic [WEIGHT_W-1:0]  keep_weight_reg;
    logic [MAG_W-1:0]     mag_low_reg;
    logic [MAG_W-1:0]     mag_high_reg;

    // captured sample and first-stage products
    logic signed [IN_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [GP_W-1:0]  gpx_reg, gpy_reg;
    logic [SUMM_W-1:0]       mag_reg;

    // filter state
    logic signed [ANG_W-1:0] pitch_reg, roll_reg;
    logic                    apply_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [ANG_W-1:0] pitch_out_reg, roll_out_reg;
    logic                    applied_out_reg;

    // FSM outputs
    logic in_accept;
    logic lane_start;
    logic merge_start;
    logic out_load;

    logic                    window;
    logic signed [ANG_W-1:0] pitch_int, roll_int;

    logic                    pitch_lane_done, roll_lane_done;
    logic signed [ACC_W-1:0] pitch_acc, roll_acc;
    logic                    merge_done;
    logic signed [ANG_W-1:0] pitch_merged, roll_merged;

    // pitch lane: atan2(ay, az)
    cft_cordic #(
        .STEPS     (CORDIC_STEPS),
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_lane_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .y_in  (ay_reg),
        .x_in  (az_reg),
        .done  (pitch_lane_done),
        .angle (pitch_acc)
    );

    // roll lane: atan2(ax, az)
    cft_cordic #(
        .STEPS     (CORDIC_STEPS),
        .FRAC_BITS (ANGLE_FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_lane_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .y_in  (ax_reg),
        .x_in  (az_reg),
        .done  (roll_lane_done),
        .angle (roll_acc)
    );

    cft_merge #(
        .ACC_W (ACC_W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (merge_start),
        .pitch_in  (pitch_reg),
        .roll_in   (roll_reg),
        .acc_pitch (pitch_acc),
        .acc_roll  (roll_acc),
        .keep      (keep_weight_reg),
        .done      (merge_done),
        .pitch_new (pitch_merged),
        .roll_new  (roll_merged)
    );

    // gyro integration and the strict magnitude window
    always_comb
    begin
        pitch_int = sat32(SAT_W'(pitch_reg) + SAT_W'(gpx_reg));
        roll_int  = sat32(SAT_W'(roll_reg) - SAT_W'(gpy_reg));
        window    = (mag_reg > SUMM_W'(mag_low_reg)) && (mag_reg < SUMM_W'(mag_high_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        in_accept   = 1'b0;
        lane_start  = 1'b0;
        merge_start = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    in_accept  = 1'b1;
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                if (window)
                begin
                    lane_start = 1'b1;
                    state_next = ST_CORDIC;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_CORDIC:
            begin
                if (pitch_lane_done)
                begin
                    merge_start = 1'b1;
                    state_next  = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (merge_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for a free output slot
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration, filter angles and out_valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_gain_reg   <= GAIN_W'(10);
            keep_weight_reg <= WEIGHT_W'(64225);
            mag_low_reg     <= MAG_W'(8192);
            mag_high_reg    <= MAG_W'(32768);
            pitch_reg       <= '0;
            roll_reg        <= '0;
            apply_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GYRO_GAIN:   gyro_gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_KEEP_WEIGHT: keep_weight_reg <= cfg_data[WEIGHT_W-1:0];
                    CFG_MAG_LOW:     mag_low_reg     <= cfg_data[MAG_W-1:0];
                    CFG_MAG_HIGH:    mag_high_reg    <= cfg_data[MAG_W-1:0];
                    default:         ;
                endcase
            end

            if (state_reg == ST_INTEG)
            begin
                pitch_reg <= pitch_int;
                roll_reg  <= roll_int;
                apply_reg <= window;
            end
            else if ((state_reg == ST_MERGE) && merge_done)
            begin
                pitch_reg <= pitch_merged;
                roll_reg  <= roll_merged;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ax_reg  <= accel_x;
            ay_reg  <= accel_y;
            az_reg  <= accel_z;
            gpx_reg <= GP_W'(gyro_x) * GP_W'($signed({1'b0, gyro_gain_reg}));
            gpy_reg <= GP_W'(gyro_y) * GP_W'($signed({1'b0, gyro_gain_reg}));
            mag_reg <= SUMM_W'(abs16(accel_x)) + SUMM_W'(abs16(accel_y))
                     + SUMM_W'(abs16(accel_z));
        end
        if (out_load)
        begin
            pitch_out_reg   <= pitch_reg;
            roll_out_reg    <= roll_reg;
            applied_out_reg <= apply_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pitch_out     = pitch_out_reg;
    assign roll_out      = roll_out_reg;
    assign accel_applied = applied_out_reg;

    `ASSERT_IMP(a_lanes_in_step, pitch_lane_done || roll_lane_done, pitch_lane_done && roll_lane_done)
    `ASSERT_IMP(a_lane_done_state, pitch_lane_done, state_reg == ST_CORDIC)
    `ASSERT_IMP(a_merge_done_state, merge_done, state_reg == ST_MERGE)
    `ASSERT_IMP(a_no_overwrite, out_valid_reg && out_stall, !out_load)

endmodule
